>>> design/cwc_pkg.sv
// cwc_pkg: shared types, codes and decode helpers for the character-word CPU.
// No dependencies.
package cwc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned PC_W   = 7;

    localparam logic [WORD_W-1:0] SPACES = 32'h2020_2020;

    // input item operations
    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_START = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
    localparam logic [OP_W-1:0] OP_DATA  = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OUT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HALT = 2'd3;

    // instruction characters
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_WAIT = 2'd2,
        MODE_HALT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OPER,
        ST_PD,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        I_NOP,
        I_LR,
        I_SR,
        I_CR,
        I_BT,
        I_GD,
        I_PD,
        I_H
    } t_instr;

    typedef struct packed {
        logic we;
        logic clr;
    } t_mem_ctl;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
        logic              last;
        logic [PC_W-1:0]   pc;
    } t_result;

    function automatic t_instr decode(input logic [WORD_W-1:0] ir);
        logic [7:0] c0;
        logic [7:0] c1;
        t_instr     res;
        c0 = ir[31:24];
        c1 = ir[23:16];
        res = I_NOP;
        if (c0 == CH_L && c1 == CH_R) res = I_LR;
        else if (c0 == CH_S && c1 == CH_R) res = I_SR;
        else if (c0 == CH_C && c1 == CH_R) res = I_CR;
        else if (c0 == CH_B && c1 == CH_T) res = I_BT;
        else if (c0 == CH_G && c1 == CH_D) res = I_GD;
        else if (c0 == CH_P && c1 == CH_D) res = I_PD;
        else if (c0 == CH_H && c1 == CH_SPACE) res = I_H;
        return res;
    endfunction

    function automatic logic [KIND_W-1:0] status_kind(input t_mode mode);
        logic [KIND_W-1:0] k;
        case (mode)
            MODE_WAIT: k = KIND_WAIT;
            MODE_HALT: k = KIND_HALT;
            default:   k = KIND_DONE;
        endcase
        return k;
    endfunction

endpackage

>>> design/cwc_ram.sv
// cwc_ram: single-port word memory, registered read.
// Per-entry valid bits make never-written words read as spaces. Uses cwc_pkg.
module cwc_ram #(
    parameter int unsigned MEM_WORDS = 128,
    parameter int unsigned AW        = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cwc_pkg::t_mem_ctl            i_ctl,
    input  logic [AW-1:0]                i_addr,
    input  logic [cwc_pkg::WORD_W-1:0]   i_wdata,
    output logic [cwc_pkg::WORD_W-1:0]   o_rdata
);

    logic [cwc_pkg::WORD_W-1:0] r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0]       r_vld;
    logic [cwc_pkg::WORD_W-1:0] r_rdata;
    logic                       r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_vld[i_addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_addr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : cwc_pkg::SPACES;

endmodule

>>> design/cwc_core.sv
// cwc_core: sequencer, architectural registers and instruction execution.
// Drives the word memory port; uses cwc_pkg.
module cwc_core #(
    parameter int unsigned MEM_WORDS   = 128,
    parameter int unsigned BLOCK_WORDS = 10,
    parameter int unsigned AW          = 7,
    parameter int unsigned CW          = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [cwc_pkg::OP_W-1:0]     i_op,
    input  logic [cwc_pkg::WORD_W-1:0]   i_word,
    input  logic                         i_slot_free,
    output logic                         o_res_valid,
    output cwc_pkg::t_result             o_res,
    output cwc_pkg::t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]                o_mem_addr,
    output logic [cwc_pkg::WORD_W-1:0]   o_mem_wdata,
    input  logic [cwc_pkg::WORD_W-1:0]   i_mem_rdata
);

    localparam int unsigned UW  = 14;
    localparam int unsigned MIN_ADDR = 528;
    localparam int unsigned OFS = MEM_WORDS * ((MIN_ADDR + MEM_WORDS - 1) / MEM_WORDS);
    localparam logic [AW-1:0] ADDR_MAX = AW'(MEM_WORDS - 1);
    localparam logic [CW-1:0] IDX_LAST = CW'(BLOCK_WORDS - 1);

    cwc_pkg::t_state r_state, n_state;
    cwc_pkg::t_mode  r_mode, n_mode;
    cwc_pkg::t_instr r_instr, n_instr;
    logic [cwc_pkg::WORD_W-1:0] r_acc, n_acc;
    logic [AW-1:0]   r_pc, n_pc;
    logic            r_flag, n_flag;
    logic [AW-1:0]   r_lp, n_lp;
    logic [AW-1:0]   r_base, n_base;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_paddr, n_paddr;
    logic [CW-1:0]   r_idx, n_idx;

    cwc_pkg::t_instr ex_instr;
    logic [AW-1:0]   ex_addr;
    logic [AW-1:0]   data_addr;
    logic [AW:0]     data_sum;

    function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
        return (a == ADDR_MAX) ? '0 : a + 1'b1;
    endfunction

    // two decimal digit characters -> address modulo MEM_WORDS
    function automatic logic [AW-1:0] wrap_addr(input logic [7:0] d2, input logic [7:0] d3);
        logic signed [UW-1:0] a;
        logic [UW-1:0]        u;
        logic [UW-1:0]        m;
        a = (signed'({{(UW-8){1'b0}}, d2}) - signed'(UW'(cwc_pkg::CH_ZERO)))
            * signed'(UW'(10))
            + signed'({{(UW-8){1'b0}}, d3}) - signed'(UW'(cwc_pkg::CH_ZERO));
        u = unsigned'(a) + UW'(OFS);
        for (int k = 4; k >= 0; k--) begin
            m = UW'(MEM_WORDS) << k;
            if (u >= m) u = u - m;
        end
        return u[AW-1:0];
    endfunction

    assign ex_instr   = cwc_pkg::decode(i_mem_rdata);
    assign ex_addr    = wrap_addr(i_mem_rdata[15:8], i_mem_rdata[7:0]);
    assign data_sum   = {1'b0, r_base} + (AW+1)'(r_cnt);
    assign data_addr  = (data_sum >= (AW+1)'(MEM_WORDS))
                        ? AW'(data_sum - (AW+1)'(MEM_WORDS)) : data_sum[AW-1:0];
    assign o_in_ready = (r_state == cwc_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            cwc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == cwc_pkg::OP_STEP && r_mode == cwc_pkg::MODE_RUN) begin
                        n_state = cwc_pkg::ST_EXEC;
                    end else begin
                        n_state = cwc_pkg::ST_EMIT;
                    end
                end
            end
            cwc_pkg::ST_EXEC: begin
                case (ex_instr)
                    cwc_pkg::I_LR, cwc_pkg::I_CR: n_state = cwc_pkg::ST_OPER;
                    cwc_pkg::I_PD:                n_state = cwc_pkg::ST_PD;
                    default:                      n_state = cwc_pkg::ST_EMIT;
                endcase
            end
            cwc_pkg::ST_OPER: n_state = cwc_pkg::ST_EMIT;
            cwc_pkg::ST_PD: begin
                if (i_slot_free && r_idx == IDX_LAST) n_state = cwc_pkg::ST_IDLE;
            end
            cwc_pkg::ST_EMIT: begin
                if (i_slot_free) n_state = cwc_pkg::ST_IDLE;
            end
            default: n_state = cwc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_instr     = r_instr;
        n_acc       = r_acc;
        n_pc        = r_pc;
        n_flag      = r_flag;
        n_lp        = r_lp;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_paddr     = r_paddr;
        n_idx       = r_idx;
        o_mem_ctl   = '0;
        o_mem_addr  = r_pc;
        o_mem_wdata = i_word;
        o_res_valid = 1'b0;
        o_res.kind  = cwc_pkg::status_kind(r_mode);
        o_res.word  = '0;
        o_res.last  = 1'b1;
        o_res.pc    = r_pc[cwc_pkg::PC_W-1:0];
        case (r_state)
            cwc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        cwc_pkg::OP_INIT: begin
                            o_mem_ctl.clr = 1'b1;
                            n_mode = cwc_pkg::MODE_IDLE;
                            n_acc  = cwc_pkg::SPACES;
                            n_pc   = '0;
                            n_flag = 1'b0;
                            n_lp   = '0;
                            n_base = '0;
                            n_cnt  = '0;
                        end
                        cwc_pkg::OP_LOAD: begin
                            o_mem_ctl.we = 1'b1;
                            o_mem_addr   = r_lp;
                            n_lp         = inc_addr(r_lp);
                        end
                        cwc_pkg::OP_START: begin
                            n_pc   = '0;
                            n_mode = cwc_pkg::MODE_RUN;
                        end
                        cwc_pkg::OP_STEP: begin
                            if (r_mode == cwc_pkg::MODE_RUN) begin
                                o_mem_addr = r_pc;
                                n_pc       = inc_addr(r_pc);
                            end
                        end
                        cwc_pkg::OP_DATA: begin
                            if (r_mode == cwc_pkg::MODE_WAIT) begin
                                o_mem_ctl.we = 1'b1;
                                o_mem_addr   = data_addr;
                                if (r_cnt == IDX_LAST) begin
                                    n_cnt  = '0;
                                    n_mode = cwc_pkg::MODE_RUN;
                                end else begin
                                    n_cnt = r_cnt + 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cwc_pkg::ST_EXEC: begin
                n_instr = ex_instr;
                case (ex_instr)
                    cwc_pkg::I_LR, cwc_pkg::I_CR: o_mem_addr = ex_addr;
                    cwc_pkg::I_SR: begin
                        o_mem_ctl.we = 1'b1;
                        o_mem_addr   = ex_addr;
                        o_mem_wdata  = r_acc;
                    end
                    cwc_pkg::I_BT: begin
                        if (r_flag) n_pc = ex_addr;
                    end
                    cwc_pkg::I_GD: begin
                        n_base = ex_addr;
                        n_cnt  = '0;
                        n_mode = cwc_pkg::MODE_WAIT;
                    end
                    cwc_pkg::I_PD: begin
                        o_mem_addr = ex_addr;
                        n_paddr    = ex_addr;
                        n_idx      = '0;
                    end
                    cwc_pkg::I_H: n_mode = cwc_pkg::MODE_HALT;
                    default: ;
                endcase
            end
            cwc_pkg::ST_OPER: begin
                if (r_instr == cwc_pkg::I_LR) begin
                    n_acc = i_mem_rdata;
                end else begin
                    n_flag = (r_acc == i_mem_rdata);
                end
            end
            cwc_pkg::ST_PD: begin
                // re-read the same word while the output slot is busy
                o_mem_addr = r_paddr;
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = cwc_pkg::KIND_OUT;
                    o_res.word  = i_mem_rdata;
                    o_res.last  = (r_idx == IDX_LAST);
                    if (r_idx != IDX_LAST) begin
                        o_mem_addr = inc_addr(r_paddr);
                        n_paddr    = inc_addr(r_paddr);
                        n_idx      = r_idx + 1'b1;
                    end
                end
            end
            cwc_pkg::ST_EMIT: o_res_valid = i_slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwc_pkg::ST_IDLE;
            r_mode  <= cwc_pkg::MODE_IDLE;
            r_instr <= cwc_pkg::I_NOP;
            r_acc   <= cwc_pkg::SPACES;
            r_pc    <= '0;
            r_flag  <= 1'b0;
            r_lp    <= '0;
            r_base  <= '0;
            r_cnt   <= '0;
            r_paddr <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_instr <= n_instr;
            r_acc   <= n_acc;
            r_pc    <= n_pc;
            r_flag  <= n_flag;
            r_lp    <= n_lp;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
            r_paddr <= n_paddr;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> design/char_word_cpu_with_io_traps.sv
// char_word_cpu_with_io_traps: top level of the character-word CPU.
// Instantiates cwc_core and cwc_ram, holds the result register; uses cwc_pkg.
//
// Usage:
//   Slave stream carries one command per transaction: tuser = op (init, load,
//   start, step, data), tdata = word. Master stream carries results: tuser =
//   kind, tdata = {pc, out_word}, tlast marks the last result of a command.
//   Path from accept to result in the output register: init, load, start,
//   data and non-running step go straight to emit; SR, BT, GD, H and unknown
//   opcodes pass through execute first; LR and CR through execute and
//   operand. PD passes execute, then gives one word per cycle while the
//   output register is free. Single-port memory: fetch, then operand access.
//   A new command is accepted once the previous one's last result has moved
//   into the output register, so it overlaps with that result waiting.
//   A stalled receiver holds the output register; PD re-reads the same word
//   until the register frees. Reset (and init) clear mode, accumulator, pc,
//   flag, load and data pointers, and make all memory read as spaces at once.
module char_word_cpu_with_io_traps #(
    parameter int unsigned MEM_WORDS   = 128,
    parameter int unsigned BLOCK_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // word[31:0]
    input  logic [2:0]  i_s_tuser,   // op[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_word[31:0], pc[38:32], zero[39]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam int unsigned CW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    cwc_pkg::t_mem_ctl          mem_ctl;
    logic [AW-1:0]              mem_addr;
    logic [cwc_pkg::WORD_W-1:0] mem_wdata;
    logic [cwc_pkg::WORD_W-1:0] mem_rdata;
    logic                       res_valid;
    cwc_pkg::t_result           res;
    logic                       slot_free;
    logic                       r_m_valid;
    cwc_pkg::t_result           r_res;

    assign slot_free = !r_m_valid || i_m_tready;

    cwc_core #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS),
        .AW          (AW),
        .CW          (CW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_op        (i_s_tuser),
        .i_word      (i_s_tdata),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    cwc_ram #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_res.pc, r_res.word};
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;

endmodule

>>> design/cwc_checker.sv
// cwc_props: port-level assertions for char_word_cpu_with_io_traps, with bind.
// Uses cwc_pkg.
module cwc_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second command accepted back to back");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != cwc_pkg::KIND_OUT |-> o_m_tlast)
        else $error("status result without tlast");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != cwc_pkg::KIND_OUT |-> o_m_tdata[31:0] == 32'd0)
        else $error("status result carries a data word");

endmodule

bind char_word_cpu_with_io_traps cwc_props u_cwc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
